@@ src/mdc_pkg.sv @@
// ----------------------------------------------------------------------------
// mdc_pkg: shared types and constants of the digit classifier
// Network dimensions, weight store layout, payload structs and control codes.
// ----------------------------------------------------------------------------
package mdc_pkg;

  localparam int INPUTS      = 784;
  localparam int HIDDEN      = 20;
  localparam int OUTPUTS     = 10;

  localparam int L1_STRIDE   = INPUTS + 1;
  localparam int L2_BASE     = L1_STRIDE * HIDDEN;
  localparam int L3_BASE     = L2_BASE + (HIDDEN + 1) * HIDDEN;
  localparam int STORE_DEPTH = L3_BASE + (HIDDEN + 1) * OUTPUTS;

  localparam int ADDR_W  = 14;
  localparam int WGT_W   = 16;
  localparam int PIX_W   = 8;
  localparam int DIGIT_W = 4;
  localparam int ACT_W   = 15;                 // sigmoid output, Q0.15
  localparam int OPND_W  = 16;                 // activation operand, up to 1.0
  localparam int PROD_W  = 32;                 // operand times weight
  localparam int ACC_W   = 40;                 // first-layer accumulator
  localparam int MAC_W   = 36;                 // layer two and three sums
  localparam int SUM_W   = 41;                 // value handed to the sigmoid
  localparam int CNT_W   = $clog2(INPUTS);
  localparam int NRN_W   = $clog2(HIDDEN);
  localparam int TERM_W  = $clog2(HIDDEN + 1);

  // round(pixel * 32768 / 255) = ({pixel, 127} * RECIP_255) >> 31
  localparam int RECIP_W   = 24;
  localparam int RECIP_255 = 8421505;
  localparam int SCALE_SH  = 31;

  localparam logic [OPND_W-1:0] ONE_Q15 = OPND_W'(32768);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic                     op;
    logic [ADDR_W-1:0]        weight_index;
    logic signed [WGT_W-1:0]  weight_value;
    logic [PIX_W-1:0]         pixel;
  } item_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [ACT_W-1:0]   best_score;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_L1_PIX,
    ST_L1_BIAS,
    ST_L2,
    ST_L3,
    ST_WAIT
  } state_t;

  typedef enum logic [1:0] {
    K_PIX,
    K_BIAS,
    K_L2,
    K_L3
  } kind_t;

  typedef struct packed {
    logic shift;
    logic add_en;
    logic clr;
  } cell_ctl_t;

endpackage

@@ src/mdc_cell.sv @@
// ----------------------------------------------------------------------------
// mdc_cell: one accumulator cell of the first-layer ring
// Holds one neuron sum; on shift takes its neighbor's sum, optionally adding a
// term with saturation or loading zero.
// ----------------------------------------------------------------------------
module mdc_cell
  import mdc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cell_ctl_t                 ctl,
  input  logic signed [ACC_W-1:0]   prev,
  input  logic signed [PROD_W-1:0]  term,
  output logic signed [ACC_W-1:0]   sum
);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic signed [ACC_W:0]   wide;
  logic signed [ACC_W-1:0] sat;

  always_comb begin
    wide = {prev[ACC_W-1], prev} + (ACC_W+1)'(term);
    if (wide[ACC_W] != wide[ACC_W-1]) begin
      sat = wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat = wide[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctl.shift) begin
      if (ctl.clr) begin
        sum <= '0;
      end else if (ctl.add_en) begin
        sum <= sat;
      end else begin
        sum <= prev;
      end
    end
  end

endmodule

@@ src/mdc_sigmoid.sv @@
// ----------------------------------------------------------------------------
// mdc_sigmoid: saturating sigmoid lookup
// Clamps a Q.27 sum to [-8,8) and reads a 1024-entry constant table in Q0.15.
// ----------------------------------------------------------------------------
module mdc_sigmoid
  import mdc_pkg::*;
(
  input  logic signed [SUM_W-1:0] v,
  output logic [ACT_W-1:0]        y
);

  localparam int TAB_N = 1024;
  localparam int HALF  = TAB_N / 2;
  localparam logic [63:0] EXP_STEP = 64'd2114190000;

  // e^(-n/64) in Q31, by repeated multiplication
  function automatic logic [63:0] exp_q31(input int n);
    logic [63:0] e;
    e = 64'd1 << 31;
    for (int m = 0; m < n; m++) begin
      e = (e * EXP_STEP) >> 31;
    end
    return e;
  endfunction

  wire [ACT_W-1:0] tab [0:TAB_N-1];

  for (genvar n = 0; n <= HALF; n++) begin : g_tab
    localparam logic [63:0] S = (64'd1 << 46) / ((64'd1 << 31) + exp_q31(n));
    localparam logic [ACT_W-1:0] HI = (S > 64'd32767) ? ACT_W'(32767) : S[ACT_W-1:0];
    localparam logic [ACT_W-1:0] LO = ACT_W'(64'd32768 - S);
    if (n < HALF) begin : g_hi
      assign tab[HALF + n] = HI;
    end
    if (n >= 1) begin : g_lo
      assign tab[HALF - n] = LO;
    end
  end

  localparam logic signed [SUM_W-1:0] LIM_HI = SUM_W'((64'd1 << 30) - 64'd1);
  localparam logic signed [SUM_W-1:0] LIM_LO = -SUM_W'(64'd1 << 30);

  logic [9:0] idx;

  always_comb begin
    if (v > LIM_HI) begin
      idx = '1;
    end else if (v < LIM_LO) begin
      idx = '0;
    end else begin
      idx = {~v[30], v[29:21]};
    end
    y = tab[idx];
  end

endmodule

@@ src/mlp_digit_classifier.sv @@
// ----------------------------------------------------------------------------
// mlp_digit_classifier: 784-20-20-10 sigmoid network inference
// Weight store, first-layer accumulator ring, shared MAC and output argmax.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): op = load writes one Q4.12
//   weight or bias at weight_index (ignored beyond the store); op = pixel
//   feeds the next pixel of the current image.
//   result channel (result_valid / result_stall / result): one transaction
//   per image, after its 784th pixel: digit and best_score (Q0.15).
// Operation:
//   A load is written as it is taken. A pixel holds item_stall high while
//   it is processed: the weight store has one read port, so the 20
//   first-layer weights are read one per cycle while the 20 accumulators
//   rotate through a ring of cells past the adder. The last pixel adds the
//   bias pass, layer two, layer three and a pipeline drain.
// Reset clears the ring accumulators, the pixel count and all valid flags; the
//   weight store keeps whatever it holds and must be loaded before use.
// A stalled result holds in its output register; new items are still taken
//   until the next image's result is ready and needs that register free.
// ----------------------------------------------------------------------------
module mlp_digit_classifier
  import mdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  // sequencer
  state_t state, state_next;

  logic [CNT_W-1:0]  pix_cnt;
  logic [ADDR_W-1:0] rd_addr;
  logic [NRN_W-1:0]  nrn;
  logic [TERM_W-1:0] term_i;
  logic [OPND_W-1:0] a_reg;

  logic nrn_last;
  logic out_last;
  logic term_last;
  logic pix_last;

  assign nrn_last  = (nrn == NRN_W'(HIDDEN - 1));
  assign out_last  = (nrn == NRN_W'(OUTPUTS - 1));
  assign term_last = (term_i == TERM_W'(HIDDEN));
  assign pix_last  = (pix_cnt == CNT_W'(INPUTS - 1));

  logic item_take;
  assign item_stall = (state != ST_IDLE);
  assign item_take  = item_valid && !item_stall;

  // scale pixel to Q1.15 by reciprocal multiplication
  logic [PIX_W+15+RECIP_W-1:0] scale_prod;
  logic [OPND_W-1:0]           a_next;

  always_comb begin
    scale_prod = (PIX_W+15+RECIP_W)'({item.pixel, 15'd127})
               * (PIX_W+15+RECIP_W)'(RECIP_255);
    a_next     = scale_prod[SCALE_SH +: OPND_W];
  end

  // weight store
  logic [WGT_W-1:0] wstore [STORE_DEPTH];
  logic signed [WGT_W-1:0] rd_data;
  logic issue;
  logic wr_en;

  assign wr_en = item_take && (item.op == OP_LOAD)
              && (item.weight_index < ADDR_W'(STORE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wstore[item.weight_index] <= item.weight_value;
    end
    if (issue) begin
      rd_data <= wstore[rd_addr];
    end
  end

  // hidden activations
  logic [ACT_W-1:0] act1 [HIDDEN];
  logic [ACT_W-1:0] act2 [HIDDEN];

  // next state
  logic pipe_empty;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_take && item.op == OP_PIXEL) state_next = ST_L1_PIX;
      end
      ST_L1_PIX: begin
        if (nrn_last) state_next = pix_last ? ST_L1_BIAS : ST_IDLE;
      end
      ST_L1_BIAS: begin
        if (nrn_last) state_next = ST_L2;
      end
      ST_L2: begin
        if (nrn_last && term_last) state_next = ST_L3;
      end
      ST_L3: begin
        if (out_last && term_last) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (pipe_empty && !result_valid) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // issue outputs: read request, its kind and the operand that meets the weight
  kind_t             issue_kind;
  logic [OPND_W-1:0] issue_opnd;
  logic [NRN_W-1:0]  term_idx;

  assign term_idx = term_i[NRN_W-1:0];

  always_comb begin
    issue      = 1'b0;
    issue_kind = K_PIX;
    issue_opnd = a_reg;
    unique case (state)
      ST_L1_PIX: begin
        issue = 1'b1;
      end
      ST_L1_BIAS: begin
        issue      = 1'b1;
        issue_kind = K_BIAS;
        issue_opnd = ONE_Q15;
      end
      ST_L2: begin
        issue      = 1'b1;
        issue_kind = K_L2;
        issue_opnd = term_last ? ONE_Q15 : OPND_W'(act1[term_idx]);
      end
      ST_L3: begin
        issue      = 1'b1;
        issue_kind = K_L3;
        issue_opnd = term_last ? ONE_Q15 : OPND_W'(act2[term_idx]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // counters and address walk
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_cnt <= '0;
      nrn     <= '0;
      term_i  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_take && item.op == OP_PIXEL) begin
            a_reg   <= a_next;
            rd_addr <= ADDR_W'(pix_cnt);
            nrn     <= '0;
          end
        end
        ST_L1_PIX: begin
          if (nrn_last) begin
            nrn     <= '0;
            rd_addr <= ADDR_W'(INPUTS);
            pix_cnt <= pix_last ? '0 : pix_cnt + 1'b1;
          end else begin
            rd_addr <= rd_addr + ADDR_W'(L1_STRIDE);
            nrn     <= nrn + 1'b1;
          end
        end
        ST_L1_BIAS: begin
          if (nrn_last) begin
            nrn     <= '0;
            term_i  <= '0;
            rd_addr <= ADDR_W'(L2_BASE);
          end else begin
            rd_addr <= rd_addr + ADDR_W'(L1_STRIDE);
            nrn     <= nrn + 1'b1;
          end
        end
        ST_L2, ST_L3: begin
          // layer two and three weights are contiguous, bias last per neuron
          rd_addr <= rd_addr + 1'b1;
          if (term_last) begin
            term_i <= '0;
            nrn    <= (state == ST_L2 && nrn_last) ? '0 : nrn + 1'b1;
          end else begin
            term_i <= term_i + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // stage 1: weight read and operand
  logic              s1_valid, s1_first, s1_last;
  kind_t             s1_kind;
  logic [NRN_W-1:0]  s1_nrn;
  logic [OPND_W-1:0] s1_opnd;

  // stage 2: product
  logic                     s2_valid, s2_first, s2_last;
  kind_t                    s2_kind;
  logic [NRN_W-1:0]         s2_nrn;
  logic signed [PROD_W-1:0] s2_prod;
  logic signed [PROD_W+1:0] prod_full;

  assign prod_full = $signed({1'b0, s1_opnd}) * rd_data;

  // stage 3: value into the sigmoid
  logic                    s3_valid;
  kind_t                   s3_kind;
  logic [NRN_W-1:0]        s3_nrn;
  logic signed [SUM_W-1:0] s3_v;

  logic signed [MAC_W-1:0] mac_acc;
  logic signed [MAC_W-1:0] mac_sum;

  assign pipe_empty = !s1_valid && !s2_valid && !s3_valid;

  // first-layer ring: neuron j sits in cell HIDDEN-1-j between pixel passes
  logic signed [ACC_W-1:0] ring [HIDDEN];
  cell_ctl_t ctl_head, ctl_pass;

  always_comb begin
    ctl_head.shift  = s2_valid && (s2_kind == K_PIX || s2_kind == K_BIAS);
    ctl_head.add_en = (s2_kind == K_PIX);
    ctl_head.clr    = (s2_kind == K_BIAS);
    ctl_pass.shift  = ctl_head.shift;
    ctl_pass.add_en = 1'b0;
    ctl_pass.clr    = 1'b0;
  end

  for (genvar g = 0; g < HIDDEN; g++) begin : g_ring
    if (g == 0) begin : g_head
      mdc_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctl  (ctl_head),
        .prev (ring[HIDDEN-1]),
        .term (s2_prod),
        .sum  (ring[g])
      );
    end else begin : g_body
      mdc_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctl  (ctl_pass),
        .prev (ring[g-1]),
        .term (s2_prod),
        .sum  (ring[g])
      );
    end
  end

  assign mac_sum = (s2_first ? '0 : mac_acc) + MAC_W'(s2_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid && (s2_kind == K_BIAS || s2_last);
    end
  end

  always_ff @(posedge clk) begin
    s1_kind  <= issue_kind;
    s1_nrn   <= nrn;
    s1_opnd  <= issue_opnd;
    s1_first <= (term_i == '0);
    s1_last  <= term_last;

    s2_kind  <= s1_kind;
    s2_nrn   <= s1_nrn;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_prod  <= prod_full[PROD_W-1:0];

    s3_kind  <= s2_kind;
    s3_nrn   <= s2_nrn;

    if (s2_valid) begin
      if (s2_kind == K_BIAS) begin
        // bias joins the ring head without accumulator saturation
        s3_v <= SUM_W'(ring[HIDDEN-1]) + SUM_W'(s2_prod);
      end else if (s2_kind == K_L2 || s2_kind == K_L3) begin
        if (s2_last) begin
          s3_v <= SUM_W'(mac_sum);
        end else begin
          mac_acc <= mac_sum;
        end
      end
    end
  end

  // sigmoid and writeback
  logic [ACT_W-1:0]   sig;
  logic [DIGIT_W-1:0] best_digit;
  logic [ACT_W-1:0]   best_score;

  mdc_sigmoid u_sigmoid (
    .v (s3_v),
    .y (sig)
  );

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      case (s3_kind)
        K_BIAS: act1[s3_nrn] <= sig;
        K_L2:   act2[s3_nrn] <= sig;
        K_L3: begin
          // keep the first maximum
          if (s3_nrn == '0 || sig > best_score) begin
            best_score <= sig;
            best_digit <= DIGIT_W'(s3_nrn);
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_WAIT && pipe_empty && !result_valid) begin
      result_valid      <= 1'b1;
      result.digit      <= best_digit;
      result.best_score <= best_score;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_pix_range: assert property (@(posedge clk) disable iff (rst)
    pix_cnt < CNT_W'(INPUTS))
    else $error("pixel count out of range");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_WAIT && $past(pipe_empty))
    else $error("result raised outside final drain");

  a_bias_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_L1_BIAS |-> pix_cnt == '0)
    else $error("bias pass with pixels pending");

  a_l3_index: assert property (@(posedge clk) disable iff (rst)
    s3_valid && s3_kind == K_L3 |-> s3_nrn < NRN_W'(OUTPUTS))
    else $error("output neuron index out of range");
`endif

endmodule

@@ tb/mlp_digit_classifier_tb.sv @@
// ----------------------------------------------------------------------------
// mlp_digit_classifier_tb: self-checking bench for the digit classifier
// Fills the weight store, streams whole images through the item channel and
// checks each digit/score transaction against a bit-exact in-bench network
// model. Both channels idle and stall at random, and the result side holds
// off long enough once to back the block up into its input.
// ----------------------------------------------------------------------------
module mlp_digit_classifier_tb;
  import mdc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     LIMIT_CYCLES  = 4_000_000;
  localparam int     HOLD_CYCLES   = 40_000;  // longer than two images
  localparam int     RAND_IMAGES   = 30;
  localparam int     DRAIN_CYCLES  = 800;
  localparam longint ACC_HI        = (longint'(1) << 39) - 1;
  localparam longint ACC_LO        = -(longint'(1) << 39);
  localparam longint SUM_LIM       = longint'(1) << 30;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  mlp_digit_classifier u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Network model: weight store, accumulators, pixel count, sigmoid table
  // --------------------------------------------------------------------------
  logic signed [WGT_W-1:0] wstore [STORE_DEPTH];
  longint                  l1_acc [HIDDEN];
  logic [ACT_W-1:0]        l2_act [HIDDEN];
  int                      pix_cnt;
  logic [ACT_W-1:0]        sig_lut [1024];

  result_t scores_due [$];
  int      errors = 0;
  bit      quiet = 1'b0;       // no idling on either side
  bit      hold_req = 1'b0;    // ask the result side for one long hold-off

  // Sigmoid samples: e^(-n/64) in Q31 by repeated scaling, then 2^46/(2^31+e).
  function automatic void build_sigmoid();
    longint unsigned e, s;
    e = 64'd1 << 31;
    for (int n = 0; n <= 512; n++) begin
      s = (64'd1 << 46) / ((64'd1 << 31) + e);
      if (n < 512) sig_lut[512 + n] = (s > 32767) ? 15'd32767 : s[ACT_W-1:0];
      if (n >= 1) sig_lut[512 - n] = ACT_W'(32768 - s);
      e = (e * 64'd2114190000) >> 31;
    end
  endfunction

  function automatic logic [ACT_W-1:0] squash(longint s);
    longint c;
    c = s;
    if (c < -SUM_LIM) c = -SUM_LIM;
    if (c > SUM_LIM - 1) c = SUM_LIM - 1;
    c = (c + SUM_LIM) >>> 21;
    return sig_lut[c[9:0]];
  endfunction

  // Apply one accepted item; returns 1 and the digit/score when an image ends.
  function automatic bit classify_step(item_t it, output result_t res);
    longint a, s;
    logic [ACT_W-1:0] h1 [HIDDEN];
    logic [ACT_W-1:0] v;
    int base, k;
    res = '0;
    if (it.op == OP_LOAD) begin
      if (it.weight_index < STORE_DEPTH) wstore[it.weight_index] = it.weight_value;
      return 1'b0;
    end
    a = (longint'(it.pixel) * 32768 + 127) / 255;
    k = (pix_cnt >= INPUTS) ? 0 : pix_cnt;
    for (int j = 0; j < HIDDEN; j++) begin
      s = l1_acc[j] + a * longint'(wstore[j * L1_STRIDE + k]);
      if (s > ACC_HI) s = ACC_HI;
      if (s < ACC_LO) s = ACC_LO;
      l1_acc[j] = s;
    end
    pix_cnt = k + 1;
    if (pix_cnt < INPUTS) return 1'b0;

    for (int j = 0; j < HIDDEN; j++)
      h1[j] = squash(l1_acc[j] + longint'(wstore[j * L1_STRIDE + INPUTS]) * 32768);
    for (int j = 0; j < HIDDEN; j++) begin
      base = L2_BASE + j * (HIDDEN + 1);
      s = longint'(wstore[base + HIDDEN]) * 32768;
      for (int i = 0; i < HIDDEN; i++)
        s += longint'(h1[i]) * longint'(wstore[base + i]);
      l2_act[j] = squash(s);
    end
    for (int j = 0; j < OUTPUTS; j++) begin
      base = L3_BASE + j * (HIDDEN + 1);
      s = longint'(wstore[base + HIDDEN]) * 32768;
      for (int i = 0; i < HIDDEN; i++)
        s += longint'(l2_act[i]) * longint'(wstore[base + i]);
      v = squash(s);
      // strict compare keeps the first neuron on a tie
      if (j == 0 || v > res.best_score) begin
        res.best_score = v;
        res.digit = DIGIT_W'(j);
      end
    end
    for (int j = 0; j < HIDDEN; j++) l1_acc[j] = 0;
    pix_cnt = 0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Item side: offer one transaction, hold it until taken, then predict
  // --------------------------------------------------------------------------
  task automatic send(item_t it, bit use_want, result_t want);
    result_t res;
    if (!quiet && $urandom_range(0, 11) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    if (classify_step(it, res))
      scores_due.insert(scores_due.size(), use_want ? want : res);
  endtask

  function automatic logic signed [WGT_W-1:0] rand_weight();
    // mostly small weights so the sigmoid is not pinned, now and then any value
    if ($urandom_range(0, 15) == 0) return WGT_W'($urandom);
    return WGT_W'($signed($urandom_range(0, 1023)) - 512);
  endfunction

  function automatic item_t rand_load();
    item_t it;
    it = item_t'($urandom);
    it.op = OP_LOAD;
    if ($urandom_range(0, 7) == 0)
      it.weight_index = ADDR_W'($urandom_range(STORE_DEPTH, 2**ADDR_W - 1));
    else
      it.weight_index = ADDR_W'($urandom_range(0, STORE_DEPTH - 1));
    it.weight_value = rand_weight();
    return it;
  endfunction

  // Directed plan: each row repeats one item, optionally walking the address.
  typedef struct {
    item_t   it;
    int      reps;
    bit      walk;
    bit      chk;
    result_t want;
  } row_t;

  row_t plan [9];

  initial begin
    item_t it;
    result_t none;
    none = '0;
    build_sigmoid();
    for (int j = 0; j < HIDDEN; j++) l1_acc[j] = 0;
    pix_cnt = 0;

    // clear the whole store, then probe the ignored addresses
    plan[0] = '{'{OP_LOAD, 14'd0, 16'sd0, 8'd0}, STORE_DEPTH, 1'b1, 1'b0, none};
    plan[1] = '{'{OP_LOAD, 14'h3FFF, 16'sh7FFF, 8'hFF}, 1, 1'b0, 1'b0, none};
    plan[2] = '{'{OP_LOAD, 14'(STORE_DEPTH), 16'sh8000, 8'h00}, 1, 1'b0, 1'b0, none};
    // zero network: every neuron sits at sigmoid(0), first neuron wins the tie
    plan[3] = '{'{OP_PIXEL, 14'd0, 16'sd0, 8'd255}, INPUTS - 1, 1'b0, 1'b0, none};
    plan[4] = '{'{OP_PIXEL, 14'h3FFF, 16'sh7FFF, 8'd0}, 1, 1'b0, 1'b1,
                '{4'd0, 15'd16384}};
    // most negative and most positive first-layer weights: accumulators clip
    plan[5] = '{'{OP_LOAD, 14'd0, 16'sh8000, 8'd0}, L2_BASE, 1'b1, 1'b0, none};
    plan[6] = '{'{OP_PIXEL, 14'd0, 16'sd0, 8'd255}, INPUTS, 1'b0, 1'b0, none};
    plan[7] = '{'{OP_LOAD, 14'd0, 16'sh7FFF, 8'd0}, L2_BASE, 1'b1, 1'b0, none};
    plan[8] = '{'{OP_PIXEL, 14'd0, 16'sd0, 8'd255}, INPUTS, 1'b0, 1'b0, none};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[r]) begin
      for (int n = 0; n < plan[r].reps; n++) begin
        it = plan[r].it;
        if (plan[r].walk) it.weight_index = plan[r].it.weight_index + ADDR_W'(n);
        send(it, plan[r].chk, plan[r].want);
      end
    end

    // random weights everywhere, then random images with stray loads
    for (int a = 0; a < STORE_DEPTH; a++) begin
      it = rand_load();
      it.weight_index = ADDR_W'(a);
      send(it, 1'b0, none);
    end
    hold_req = 1'b1;
    for (int img = 0; img < RAND_IMAGES; img++) begin
      if (img >= RAND_IMAGES - 3) quiet = 1'b1;
      for (int p = 0; p < INPUTS; p++) begin
        if ($urandom_range(0, 19) == 0) send(rand_load(), 1'b0, none);
        it = item_t'($urandom);
        it.op = OP_PIXEL;
        it.pixel = PIX_W'($urandom_range(0, 255));
        send(it, 1'b0, none);
      end
    end
    item_valid <= 1'b0;

    while (scores_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, one long hold-off, compare in order
  // --------------------------------------------------------------------------
  int hold_cnt = 0;
  int burst = 0;

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (scores_due.size() == 0) begin
        $error("unexpected result: digit %0d best_score %0d",
               result.digit, result.best_score);
        errors++;
      end else begin
        want = scores_due.pop_front();
        if (result.digit !== want.digit) begin
          $error("digit: expected %0d, got %0d", want.digit, result.digit);
          errors++;
        end
        if (result.best_score !== want.best_score) begin
          $error("best_score: expected %0d, got %0d", want.best_score,
                 result.best_score);
          errors++;
        end
      end
    end
    // count out the long hold-off here, independent of the item side
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      result_stall <= 1'b1;
    end else if (burst > 0) begin
      burst--;
      result_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      burst = $urandom_range(0, 6);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Watchdog: abandon a hung run.
  int cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

@@ mlp_digit_classifier.f @@
src/mdc_pkg.sv
src/mdc_cell.sv
src/mdc_sigmoid.sv
src/mlp_digit_classifier.sv
tb/mlp_digit_classifier_tb.sv
